FILE: hdl/cpid_pkg.sv
// shared types, widths and codes for the curved pid controller
`timescale 1ns / 1ps
`default_nettype none

package cpid_pkg;

    localparam int ANGLE_W  = 17;
    localparam int DT_W     = 20;
    localparam int DRIVE_W  = 16;
    localparam int GAIN_W   = 32;
    localparam int CURVE_W  = 17;
    localparam int MAXO_W   = 15;
    localparam int INTEG_W  = 48;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int MUL_A_W  = 34;
    localparam int MUL_B_W  = 25;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic [CURVE_W-1:0] CURVE_ONE = 17'd65536;

    // register indexes, byte address divided by four
    localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [2:0] REG_CURVE_FACTOR = 3'd3;
    localparam logic [2:0] REG_MAX_OUTPUT   = 3'd4;

    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN    = 32'd838861;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN   = 32'd28147;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN   = 32'd0;
    localparam logic [CURVE_W-1:0] RST_CURVE_FACTOR = 17'd19661;
    localparam logic [MAXO_W-1:0]  RST_MAX_OUTPUT   = 15'd25600;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] measured_angle;
        logic [DT_W-1:0]           elapsed_us;
    } t_in;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_out;
        logic                      clamped;
    } t_out;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [CURVE_W-1:0] curve_factor;
        logic [MAXO_W-1:0]  max_output;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ED,
        ST_P,
        ST_D,
        ST_IH,
        ST_IL,
        ST_TLOW,
        ST_SUM,
        ST_CM,
        ST_NUM,
        ST_SN,
        ST_OUT
    } t_state;

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MS_NONE,
        MS_E_DT,
        MS_KP_E,
        MS_KD_DE,
        MS_KI_IH,
        MS_KI_IL,
        MS_C_MAG,
        MS_S_NUM
    } t_mul_sel;

    // what the datapath does with the last registered product or its partial sums
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_INTEG,
        ACT_P,
        ACT_D,
        ACT_T,
        ACT_TLOW,
        ACT_SUM,
        ACT_NUM
    } t_act;

    typedef struct packed {
        logic     load_in;
        t_mul_sel mul_sel;
        t_act     act;
        logic     load_out;
    } t_cmd;

endpackage

`default_nettype wire

FILE: hdl/curved_pid_controller.sv
// Curved PID controller, top level.
// Input channel (i_in_valid / o_in_ready / i_in_data): one transfer per
// sample carries the measured tilt (Q8.8) and the microseconds since the
// previous sample. Output channel (o_out_valid / i_out_ready / o_out_data):
// one transfer per sample carries the shaped, clamped drive (Q8.8) and the
// clamp flag. Gains, curve factor and clamp sit in an APB-style register
// bank at byte addresses 0x00 to 0x10; write them only while idle.
// Each sample steps seven products through one shared 34 x 25
// multiplier; no new sample is taken while one is in flight.
// The result sits in an output register, so the next sample is accepted as
// soon as the result is loaded; if the receiver stalls, the following
// sample waits in its final step until the register is free.
// Reset clears the integral and the previous error, restores the register
// defaults and drops any sample in flight.
`timescale 1ns / 1ps
`default_nettype none

module curved_pid_controller
    import cpid_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in               i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out                   o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_cfg cfg;
    t_cmd cmd;

    cpid_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cpid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    cpid_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in_data),
        .i_cfg   (cfg),
        .o_out   (o_out_data)
    );

endmodule

`default_nettype wire

FILE: hdl/cpid_regs.sv
// apb-style configuration register bank
`timescale 1ns / 1ps
`default_nettype none

module cpid_regs
    import cpid_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain    <= RST_PROP_GAIN;
            r_cfg.integ_gain   <= RST_INTEG_GAIN;
            r_cfg.deriv_gain   <= RST_DERIV_GAIN;
            r_cfg.curve_factor <= RST_CURVE_FACTOR;
            r_cfg.max_output   <= RST_MAX_OUTPUT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PROP_GAIN:    r_cfg.prop_gain    <= pwdata;
                REG_INTEG_GAIN:   r_cfg.integ_gain   <= pwdata;
                REG_DERIV_GAIN:   r_cfg.deriv_gain   <= pwdata;
                REG_CURVE_FACTOR: r_cfg.curve_factor <= pwdata[CURVE_W-1:0];
                REG_MAX_OUTPUT:   r_cfg.max_output   <= pwdata[MAXO_W-1:0];
                default: ; // unmapped addresses ignore the transfer
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PROP_GAIN:    prdata = r_cfg.prop_gain;
            REG_INTEG_GAIN:   prdata = r_cfg.integ_gain;
            REG_DERIV_GAIN:   prdata = r_cfg.deriv_gain;
            REG_CURVE_FACTOR: prdata = {{(DATA_W-CURVE_W){1'b0}}, r_cfg.curve_factor};
            REG_MAX_OUTPUT:   prdata = {{(DATA_W-MAXO_W){1'b0}}, r_cfg.max_output};
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/cpid_ctrl.sv
// sequencing state machine and handshake control
`timescale 1ns / 1ps
`default_nettype none

module cpid_ctrl
    import cpid_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // result register can take a new value this cycle
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = i_in_valid ? ST_ED : ST_IDLE;
            ST_ED:   n_state = ST_P;
            ST_P:    n_state = ST_D;
            ST_D:    n_state = ST_IH;
            ST_IH:   n_state = ST_IL;
            ST_IL:   n_state = ST_TLOW;
            ST_TLOW: n_state = ST_SUM;
            ST_SUM:  n_state = ST_CM;
            ST_CM:   n_state = ST_NUM;
            ST_NUM:  n_state = ST_SN;
            ST_SN:   n_state = ST_OUT;
            ST_OUT:  n_state = out_free ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load_in  = 1'b0;
        o_cmd.mul_sel  = MS_NONE;
        o_cmd.act      = ACT_NONE;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: o_cmd.load_in = i_in_valid;
            ST_ED:   o_cmd.mul_sel = MS_E_DT;
            ST_P: begin
                o_cmd.mul_sel = MS_KP_E;
                o_cmd.act     = ACT_INTEG;
            end
            ST_D: begin
                o_cmd.mul_sel = MS_KD_DE;
                o_cmd.act     = ACT_P;
            end
            ST_IH: begin
                o_cmd.mul_sel = MS_KI_IH;
                o_cmd.act     = ACT_D;
            end
            ST_IL: begin
                o_cmd.mul_sel = MS_KI_IL;
                o_cmd.act     = ACT_T;
            end
            ST_TLOW: o_cmd.act     = ACT_TLOW;
            ST_SUM:  o_cmd.act     = ACT_SUM;
            ST_CM:   o_cmd.mul_sel = MS_C_MAG;
            ST_NUM:  o_cmd.act     = ACT_NUM;
            ST_SN:   o_cmd.mul_sel = MS_S_NUM;
            ST_OUT:  o_cmd.load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_ED && !o_in_ready))
        else $error("accepted transfer did not start the sequence");

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_OUT))
        else $error("result raised outside the finishing step");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_out_valid && !i_out_ready) |=> (r_state == ST_OUT))
        else $error("finishing step left while previous result unread");

endmodule

`default_nettype wire

FILE: hdl/cpid_dp.sv
// datapath: shared multiplier, integral state, shaping and clamp
`timescale 1ns / 1ps
`default_nettype none

module cpid_dp
    import cpid_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire t_in  i_in,
    input  wire t_cfg i_cfg,
    output t_out      o_out
);

    logic signed [ANGLE_W-1:0] r_e;
    logic        [DT_W-1:0]    r_dt;
    logic signed [ANGLE_W-1:0] r_last_err;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [32:0]        r_acc;
    logic signed [57:0]        r_t;
    logic signed [16:0]        r_s;
    logic        [15:0]        r_mag;
    logic        [32:0]        r_num;
    t_out                      r_out;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic        [ANGLE_W:0]   neg_angle;
    logic        [ANGLE_W-1:0] e_in;
    logic        [ANGLE_W:0]   de;
    logic        [INTEG_W:0]   integ_sum;
    logic        [INTEG_W-1:0] integ_sat;
    logic        [32:0]        acc_d;
    logic        [57:0]        t_low;
    logic signed [34:0]        sum35;
    logic        [16:0]        s_sat;
    logic        [16:0]        s_neg;
    logic        [CURVE_W-1:0] c_eff;
    logic        [CURVE_W-1:0] c_rest;
    logic        [32:0]        num_next;
    logic signed [34:0]        shaped;
    logic signed [34:0]        max35;
    t_out                      out_next;

    assign o_out = r_out;

    // error is the negated angle; only the most negative angle overflows
    assign neg_angle = 18'd0 - {i_in.measured_angle[ANGLE_W-1], i_in.measured_angle};
    assign e_in = (neg_angle[ANGLE_W:ANGLE_W-1] == 2'b01) ? 17'h0FFFF
                                                          : neg_angle[ANGLE_W-1:0];

    assign de = {r_e[ANGLE_W-1], r_e} - {r_last_err[ANGLE_W-1], r_last_err};

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_E_DT: begin
                op_a = {{(MUL_A_W-DT_W){1'b0}}, r_dt};
                op_b = {{(MUL_B_W-ANGLE_W){r_e[ANGLE_W-1]}}, r_e};
            end
            MS_KP_E: begin
                op_a = {{2{i_cfg.prop_gain[GAIN_W-1]}}, i_cfg.prop_gain};
                op_b = {{(MUL_B_W-ANGLE_W){r_e[ANGLE_W-1]}}, r_e};
            end
            MS_KD_DE: begin
                op_a = {{2{i_cfg.deriv_gain[GAIN_W-1]}}, i_cfg.deriv_gain};
                op_b = {{(MUL_B_W-ANGLE_W-1){de[ANGLE_W]}}, de};
            end
            MS_KI_IH: begin
                op_a = {{2{i_cfg.integ_gain[GAIN_W-1]}}, i_cfg.integ_gain};
                op_b = {r_integ[INTEG_W-1], r_integ[INTEG_W-1:24]};
            end
            MS_KI_IL: begin
                op_a = {{2{i_cfg.integ_gain[GAIN_W-1]}}, i_cfg.integ_gain};
                op_b = {1'b0, r_integ[23:0]};
            end
            MS_C_MAG: begin
                op_a = {{(MUL_A_W-CURVE_W){1'b0}}, c_eff};
                op_b = {9'd0, r_mag};
            end
            MS_S_NUM: begin
                op_a = {1'b0, r_num};
                op_b = {{(MUL_B_W-17){r_s[16]}}, r_s};
            end
            MS_NONE: begin
                op_a = '0;
                op_b = '0;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // saturating integral update, 49-bit sum checked on its top two bits
    assign integ_sum = {r_integ[INTEG_W-1], r_integ} + {{12{r_prod[36]}}, r_prod[36:0]};
    always_comb begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                           : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end

    assign acc_d = r_acc + {{7{r_prod[49]}}, r_prod[49:24]};
    assign t_low = r_t + {{26{r_prod[55]}}, r_prod[55:24]};
    assign sum35 = {{2{r_acc[32]}}, r_acc} + {r_t[57], r_t[57:24]};

    always_comb begin
        if (sum35 > 35'sd32768) begin
            s_sat = 17'h08000;
        end else if (sum35 < -35'sd32768) begin
            s_sat = 17'h18000;
        end else begin
            s_sat = sum35[16:0];
        end
    end
    assign s_neg = 17'd0 - s_sat;

    assign c_eff    = (i_cfg.curve_factor > CURVE_ONE) ? CURVE_ONE : i_cfg.curve_factor;
    assign c_rest   = CURVE_ONE - c_eff;
    assign num_next = r_prod[32:0] + {8'd0, c_rest, 8'd0};

    assign shaped = r_prod[PROD_W-1:24];
    assign max35  = {20'd0, i_cfg.max_output};

    always_comb begin
        if (shaped > max35) begin
            out_next.drive_out = max35[DRIVE_W-1:0];
            out_next.clamped   = 1'b1;
        end else if (shaped < -max35) begin
            out_next.drive_out = 16'd0 - max35[DRIVE_W-1:0];
            out_next.clamped   = 1'b1;
        end else begin
            out_next.drive_out = shaped[DRIVE_W-1:0];
            out_next.clamped   = 1'b0;
        end
    end

    // controller state carried between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
        end else begin
            if (i_cmd.act == ACT_INTEG) begin
                r_integ <= integ_sat;
            end
            if (i_cmd.act == ACT_D) begin
                r_last_err <= r_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_e  <= e_in;
            r_dt <= i_in.elapsed_us;
        end
        if (i_cmd.mul_sel != MS_NONE) begin
            r_prod <= op_a * op_b;
        end
        unique case (i_cmd.act)
            ACT_P:    r_acc <= {{8{r_prod[48]}}, r_prod[48:24]};
            ACT_D:    r_acc <= acc_d;
            ACT_T:    r_t   <= r_prod[57:0];
            ACT_TLOW: r_t   <= t_low;
            ACT_SUM: begin
                r_s   <= s_sat;
                r_mag <= s_sat[16] ? s_neg[15:0] : s_sat[15:0];
            end
            ACT_NUM:  r_num <= num_next;
            ACT_NONE, ACT_INTEG: ;
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out <= out_next;
        end
    end

    a_drive_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=>
            ($signed(r_out.drive_out) <= $signed({1'b0, i_cfg.max_output}) &&
             $signed(r_out.drive_out) >= -$signed({1'b0, i_cfg.max_output})))
        else $error("drive value outside the clamp");

    a_flag_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=>
            (!r_out.clamped ||
             r_out.drive_out == $signed({1'b0, i_cfg.max_output}) ||
             r_out.drive_out == -$signed({1'b0, i_cfg.max_output})))
        else $error("clamped flag set with drive short of the limit");

endmodule

`default_nettype wire
